// ----- rtl/bpag_pkg.sv -----
// ============================================================================
// Block pack address generator package
// Shared types, codes and helpers for the strided 3D block address generator.
// ============================================================================
package bpag_pkg;

    localparam int unsigned MAX_GRID  = 256;
    localparam int unsigned MAX_WORDS = 4;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned INDEX_W = 26;
    localparam int unsigned GRID_W  = 9;
    localparam int unsigned START_W = 8;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned WORD_W  = 2;
    localparam int unsigned EC_W    = 3;
    localparam int unsigned PROD_W  = INDEX_W + GRID_W;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic [1:0] {
        MODE_PACK   = 2'd0,
        MODE_ROT1   = 2'd1,
        MODE_ROT2   = 2'd2,
        MODE_UNPACK = 2'd3
    } copy_mode_t;

    typedef enum logic [2:0] {
        REG_GRID_SLOW     = 3'd0,
        REG_GRID_MID      = 3'd1,
        REG_GRID_FAST     = 3'd2,
        REG_ELEMENT_COUNT = 3'd3,
        REG_COPY_MODE     = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        MAC_OUTER = 2'd0,
        MAC_INNER = 2'd1,
        MAC_SCALE = 2'd2
    } mac_step_t;

    typedef struct packed {
        logic               func;
        logic [START_W-1:0] start_slow;
        logic [START_W-1:0] start_mid;
        logic [START_W-1:0] start_fast;
        logic [GRID_W-1:0]  extent_slow;
        logic [GRID_W-1:0]  extent_mid;
        logic [GRID_W-1:0]  extent_fast;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] src_index;
        logic [INDEX_W-1:0] dst_index;
        logic               last_flag;
    } out_item_t;

    typedef struct packed {
        logic [GRID_W-1:0] grid_slow;
        logic [GRID_W-1:0] grid_mid;
        logic [GRID_W-1:0] grid_fast;
        logic [EC_W-1:0]   element_count;
        copy_mode_t        copy_mode;
    } cfg_t;

    typedef struct packed {
        logic      load;
        logic      mac_en;
        logic      pack;
        mac_step_t step;
        logic      emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } dp_status_t;

    function automatic logic [GRID_W-1:0] clamp_extent(input logic [GRID_W-1:0] v);
        logic [GRID_W-1:0] r;
        r = (v > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : v;
        return r;
    endfunction

    function automatic logic [EC_W-1:0] words_per_point(input logic [EC_W-1:0] ec);
        logic [EC_W-1:0] r;
        if (ec == '0)
        begin
            r = EC_W'(1);
        end
        else if (ec > EC_W'(MAX_WORDS))
        begin
            r = EC_W'(MAX_WORDS);
        end
        else
        begin
            r = ec;
        end
        return r;
    endfunction

endpackage

// ----- rtl/bpag_regs.sv -----
// ============================================================================
// Block pack address generator configuration registers
// APB register file holding grid extents, words per point and copy mode.
// ============================================================================
module bpag_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpag_pkg::ADDR_W-1:0]         paddr,
    input  logic [bpag_pkg::DATA_W-1:0]         pwdata,
    output logic [bpag_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output bpag_pkg::cfg_t                      cfg
);

    bpag_pkg::cfg_t         cfg_reg;
    bpag_pkg::cfg_t         cfg_next;
    bpag_pkg::reg_index_t   index;
    logic                   wr_en;

    assign index  = bpag_pkg::reg_index_t'(paddr[bpag_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                bpag_pkg::REG_GRID_SLOW:
                    cfg_next.grid_slow = pwdata[bpag_pkg::GRID_W-1:0];
                bpag_pkg::REG_GRID_MID:
                    cfg_next.grid_mid = pwdata[bpag_pkg::GRID_W-1:0];
                bpag_pkg::REG_GRID_FAST:
                    cfg_next.grid_fast = pwdata[bpag_pkg::GRID_W-1:0];
                bpag_pkg::REG_ELEMENT_COUNT:
                    cfg_next.element_count = pwdata[bpag_pkg::EC_W-1:0];
                bpag_pkg::REG_COPY_MODE:
                    cfg_next.copy_mode = bpag_pkg::copy_mode_t'(pwdata[1:0]);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            bpag_pkg::REG_GRID_SLOW:
                prdata = bpag_pkg::DATA_W'(cfg_reg.grid_slow);
            bpag_pkg::REG_GRID_MID:
                prdata = bpag_pkg::DATA_W'(cfg_reg.grid_mid);
            bpag_pkg::REG_GRID_FAST:
                prdata = bpag_pkg::DATA_W'(cfg_reg.grid_fast);
            bpag_pkg::REG_ELEMENT_COUNT:
                prdata = bpag_pkg::DATA_W'(cfg_reg.element_count);
            bpag_pkg::REG_COPY_MODE:
                prdata = bpag_pkg::DATA_W'(cfg_reg.copy_mode);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_slow     <= bpag_pkg::GRID_W'(1);
            cfg_reg.grid_mid      <= bpag_pkg::GRID_W'(1);
            cfg_reg.grid_fast     <= bpag_pkg::GRID_W'(1);
            cfg_reg.element_count <= bpag_pkg::EC_W'(1);
            cfg_reg.copy_mode     <= bpag_pkg::MODE_PACK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/bpag_ctrl.sv -----
// ============================================================================
// Block pack address generator controller
// Sequences request intake, six multiply-accumulate steps and result hand-off.
// ============================================================================
module bpag_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic                    cmd_func,
    output logic                    cmd_stall,
    input  bpag_pkg::dp_status_t    status,
    output bpag_pkg::ctrl_cmd_t     ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WAIT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    bpag_pkg::mac_step_t    step_reg;
    bpag_pkg::mac_step_t    step_next;
    logic                   pack_reg;
    logic                   pack_next;
    logic                   accept;

    assign accept    = cmd_valid && (state_reg == ST_IDLE);
    assign cmd_stall = (state_reg != ST_IDLE);

    assign ctrl.load   = accept && (cmd_func == bpag_pkg::FUNC_LOAD);
    assign ctrl.mac_en = (state_reg == ST_CALC);
    assign ctrl.pack   = pack_reg;
    assign ctrl.step   = step_reg;
    assign ctrl.emit   = (state_reg == ST_WAIT) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pack_next  = pack_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_func == bpag_pkg::FUNC_STEP) && status.active)
                begin
                    state_next = ST_CALC;
                    step_next  = bpag_pkg::MAC_OUTER;
                    pack_next  = 1'b0;
                end
            end
            ST_CALC:
            begin
                unique case (step_reg)
                    bpag_pkg::MAC_OUTER:
                        step_next = bpag_pkg::MAC_INNER;
                    bpag_pkg::MAC_INNER:
                        step_next = bpag_pkg::MAC_SCALE;
                    default:
                    begin
                        step_next = bpag_pkg::MAC_OUTER;
                        if (pack_reg)
                        begin
                            pack_next  = 1'b0;
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            pack_next = 1'b1;
                        end
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= bpag_pkg::MAC_OUTER;
            pack_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pack_reg  <= pack_next;
        end
    end

endmodule

// ----- rtl/bpag_datapath.sv -----
// ============================================================================
// Block pack address generator datapath
// Block descriptor, walk counters, shared multiply-accumulate and result stage.
// ============================================================================
module bpag_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bpag_pkg::cfg_t          cfg,
    input  bpag_pkg::in_item_t      cmd,
    input  bpag_pkg::ctrl_cmd_t     ctrl,
    output bpag_pkg::dp_status_t    status,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output bpag_pkg::out_item_t     rsp
);

    logic [bpag_pkg::START_W-1:0]   start_slow_reg;
    logic [bpag_pkg::START_W-1:0]   start_mid_reg;
    logic [bpag_pkg::START_W-1:0]   start_fast_reg;
    logic [bpag_pkg::GRID_W-1:0]    ext_slow_reg;
    logic [bpag_pkg::GRID_W-1:0]    ext_mid_reg;
    logic [bpag_pkg::GRID_W-1:0]    ext_fast_reg;
    logic                           active_reg;
    logic [bpag_pkg::CNT_W-1:0]     s_reg;
    logic [bpag_pkg::CNT_W-1:0]     m_reg;
    logic [bpag_pkg::CNT_W-1:0]     f_reg;
    logic [bpag_pkg::WORD_W-1:0]    e_reg;
    logic [bpag_pkg::INDEX_W-1:0]   acc_reg;
    logic [bpag_pkg::INDEX_W-1:0]   acc_next;
    logic [bpag_pkg::INDEX_W-1:0]   grid_reg;
    logic                           out_valid_reg;
    bpag_pkg::out_item_t            out_reg;

    logic [bpag_pkg::GRID_W-1:0]    ld_slow;
    logic [bpag_pkg::GRID_W-1:0]    ld_mid;
    logic [bpag_pkg::GRID_W-1:0]    ld_fast;
    logic [bpag_pkg::EC_W-1:0]      words;
    logic [bpag_pkg::GRID_W-1:0]    a2;
    logic [bpag_pkg::GRID_W-1:0]    a1;
    logic [bpag_pkg::GRID_W-1:0]    a0;
    logic [bpag_pkg::GRID_W-1:0]    n2;
    logic [bpag_pkg::GRID_W-1:0]    n1;
    logic [bpag_pkg::INDEX_W-1:0]   mul_a;
    logic [bpag_pkg::GRID_W-1:0]    mul_b;
    logic [bpag_pkg::GRID_W-1:0]    addend;
    logic [bpag_pkg::PROD_W-1:0]    prod;
    logic [bpag_pkg::EC_W-1:0]      e_inc;
    logic [bpag_pkg::GRID_W-1:0]    f_inc;
    logic [bpag_pkg::GRID_W-1:0]    m_inc;
    logic [bpag_pkg::GRID_W-1:0]    s_inc;
    logic                           wrap_e;
    logic                           wrap_f;
    logic                           wrap_m;
    logic                           wrap_s;
    logic                           last;
    logic                           out_free;

    assign ld_slow = bpag_pkg::clamp_extent(cmd.extent_slow);
    assign ld_mid  = bpag_pkg::clamp_extent(cmd.extent_mid);
    assign ld_fast = bpag_pkg::clamp_extent(cmd.extent_fast);
    assign words   = bpag_pkg::words_per_point(cfg.element_count);

    assign e_inc  = {1'b0, e_reg} + bpag_pkg::EC_W'(1);
    assign f_inc  = {1'b0, f_reg} + bpag_pkg::GRID_W'(1);
    assign m_inc  = {1'b0, m_reg} + bpag_pkg::GRID_W'(1);
    assign s_inc  = {1'b0, s_reg} + bpag_pkg::GRID_W'(1);
    assign wrap_e = (e_inc >= words);
    assign wrap_f = (f_inc >= ext_fast_reg);
    assign wrap_m = (m_inc >= ext_mid_reg);
    assign wrap_s = (s_inc >= ext_slow_reg);
    assign last   = wrap_e && wrap_f && wrap_m && wrap_s;

    assign out_free        = !out_valid_reg || !rsp_stall;
    assign status.active   = active_reg;
    assign status.out_free = out_free;
    assign rsp_valid       = out_valid_reg;
    assign rsp             = out_reg;

    always_comb
    begin
        if (!ctrl.pack)
        begin
            a2 = {1'b0, start_slow_reg} + {1'b0, s_reg};
            a1 = {1'b0, start_mid_reg} + {1'b0, m_reg};
            a0 = {1'b0, start_fast_reg} + {1'b0, f_reg};
            n2 = cfg.grid_mid;
            n1 = cfg.grid_fast;
        end
        else
        begin
            unique case (cfg.copy_mode)
                bpag_pkg::MODE_ROT1:
                begin
                    a2 = {1'b0, m_reg};
                    n2 = ext_fast_reg;
                    a1 = {1'b0, f_reg};
                    n1 = ext_slow_reg;
                    a0 = {1'b0, s_reg};
                end
                bpag_pkg::MODE_ROT2:
                begin
                    a2 = {1'b0, f_reg};
                    n2 = ext_slow_reg;
                    a1 = {1'b0, s_reg};
                    n1 = ext_mid_reg;
                    a0 = {1'b0, m_reg};
                end
                bpag_pkg::MODE_PACK, bpag_pkg::MODE_UNPACK:
                begin
                    a2 = {1'b0, s_reg};
                    n2 = ext_mid_reg;
                    a1 = {1'b0, m_reg};
                    n1 = ext_fast_reg;
                    a0 = {1'b0, f_reg};
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (ctrl.step)
            bpag_pkg::MAC_INNER:
            begin
                mul_a  = acc_reg;
                mul_b  = n1;
                addend = a0;
            end
            bpag_pkg::MAC_SCALE:
            begin
                mul_a  = acc_reg;
                mul_b  = bpag_pkg::GRID_W'(words);
                addend = bpag_pkg::GRID_W'(e_reg);
            end
            default:
            begin
                mul_a  = bpag_pkg::INDEX_W'(a2);
                mul_b  = n2;
                addend = a1;
            end
        endcase
    end

    assign prod     = bpag_pkg::PROD_W'(mul_a) * bpag_pkg::PROD_W'(mul_b);
    assign acc_next = prod[bpag_pkg::INDEX_W-1:0] + bpag_pkg::INDEX_W'(addend);

    always_ff @(posedge clk)
    begin
        if (ctrl.mac_en)
        begin
            acc_reg <= acc_next;
            if (!ctrl.pack && (ctrl.step == bpag_pkg::MAC_SCALE))
            begin
                grid_reg <= acc_next;
            end
        end
        if (ctrl.load)
        begin
            start_slow_reg <= cmd.start_slow;
            start_mid_reg  <= cmd.start_mid;
            start_fast_reg <= cmd.start_fast;
        end
        if (ctrl.emit)
        begin
            if (cfg.copy_mode == bpag_pkg::MODE_UNPACK)
            begin
                out_reg.src_index <= acc_reg;
                out_reg.dst_index <= grid_reg;
            end
            else
            begin
                out_reg.src_index <= grid_reg;
                out_reg.dst_index <= acc_reg;
            end
            out_reg.last_flag <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            ext_slow_reg  <= '0;
            ext_mid_reg   <= '0;
            ext_fast_reg  <= '0;
            s_reg         <= '0;
            m_reg         <= '0;
            f_reg         <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ctrl.load)
            begin
                ext_slow_reg <= ld_slow;
                ext_mid_reg  <= ld_mid;
                ext_fast_reg <= ld_fast;
                active_reg   <= (ld_slow != '0) && (ld_mid != '0) && (ld_fast != '0);
                s_reg        <= '0;
                m_reg        <= '0;
                f_reg        <= '0;
                e_reg        <= '0;
            end
            else if (ctrl.emit)
            begin
                if (last)
                begin
                    active_reg <= 1'b0;
                    s_reg      <= '0;
                    m_reg      <= '0;
                    f_reg      <= '0;
                    e_reg      <= '0;
                end
                else if (!wrap_e)
                begin
                    e_reg <= e_inc[bpag_pkg::WORD_W-1:0];
                end
                else
                begin
                    e_reg <= '0;
                    if (!wrap_f)
                    begin
                        f_reg <= f_inc[bpag_pkg::CNT_W-1:0];
                    end
                    else
                    begin
                        f_reg <= '0;
                        if (!wrap_m)
                        begin
                            m_reg <= m_inc[bpag_pkg::CNT_W-1:0];
                        end
                        else
                        begin
                            m_reg <= '0;
                            s_reg <= wrap_s ? '0 : s_inc[bpag_pkg::CNT_W-1:0];
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/block_pack_address_generator.sv -----
// ============================================================================
// Block pack address generator
// Walks a 3D sub-block and gives grid and packed word index pairs.
// ============================================================================
// Usage:
//   cmd channel: a load request (func = 0) records the block corner and
//   extents; it gives no result and cmd_stall stays low, so the next request
//   is taken in the following cycle. A step request (func = 1) on an active
//   block produces one index pair on the rsp channel; with no active block
//   it is dropped at once.
//   A step holds cmd_stall high until its pair is handed on: one shared
//   multiply-accumulate unit evaluates the grid index and the packed index
//   by Horner's rule in three steps each, then the wait state hands the
//   pair to the output register, whose valid flag drives rsp_valid.
//   The output register holds a result while rsp_stall is high; the block
//   then finishes the next step and waits with cmd_stall high until the
//   register frees.
//   Reset clears the extents, walk counters and output valid flag and sets
//   the APB registers to grid 1 x 1 x 1, one word per point, plain pack mode.
// ============================================================================
module block_pack_address_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpag_pkg::ADDR_W-1:0]     paddr,
    input  logic [bpag_pkg::DATA_W-1:0]     pwdata,
    output logic [bpag_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  bpag_pkg::in_item_t              cmd,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output bpag_pkg::out_item_t             rsp
);

    bpag_pkg::cfg_t         cfg;
    bpag_pkg::ctrl_cmd_t    ctrl;
    bpag_pkg::dp_status_t   status;

    bpag_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_func  (cmd.func),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    bpag_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .ctrl      (ctrl),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/bpag_checker.sv -----
// ============================================================================
// Block pack address generator checker
// Port-level temporal checks, bound to the top level.
// ============================================================================
module bpag_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pready,
    input  logic                    cmd_valid,
    input  logic                    cmd_stall,
    input  bpag_pkg::in_item_t      cmd,
    input  logic                    rsp_valid,
    input  logic                    rsp_stall,
    input  bpag_pkg::out_item_t     rsp
);

    logic cmd_take;

    assign cmd_take = cmd_valid && !cmd_stall;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (cmd.func == bpag_pkg::FUNC_LOAD) |=> !cmd_stall)
        else $error("load request blocked the next request");

    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !$rose(rsp_valid))
        else $error("result appeared one cycle after a request");

    a_rsp_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_stall))
        else $error("result produced while the block was idle");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind block_pack_address_generator bpag_checker u_bpag_checker (.*);

// ----- bench/testbench.sv -----
// ============================================================================
// Block pack address generator testbench
// Loads 3D block descriptors and steps through them under every copy mode,
// with random sender bursts and receiver stalls. A scoreboard predicts each
// index pair and checks the block's responses in order.
// ============================================================================
module testbench;
    import bpag_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 88;
    localparam int PHASE_COUNT    = 8;

    class pair_scoreboard;
        logic [GRID_W-1:0]  grid_dim_s;
        logic [GRID_W-1:0]  grid_dim_m;
        logic [GRID_W-1:0]  grid_dim_f;
        logic [EC_W-1:0]    word_cfg;
        copy_mode_t         mode;
        bit                 block_live;
        logic [CNT_W-1:0]   at_slow;
        logic [CNT_W-1:0]   at_mid;
        logic [CNT_W-1:0]   at_fast;
        logic [WORD_W-1:0]  at_word;
        logic [START_W-1:0] base_slow;
        logic [START_W-1:0] base_mid;
        logic [START_W-1:0] base_fast;
        logic [GRID_W-1:0]  size_slow;
        logic [GRID_W-1:0]  size_mid;
        logic [GRID_W-1:0]  size_fast;
        out_item_t          expected_pairs[$];
        int                 errors;

        function new();
            grid_dim_s = GRID_W'(1);
            grid_dim_m = GRID_W'(1);
            grid_dim_f = GRID_W'(1);
            word_cfg   = EC_W'(1);
            mode       = MODE_PACK;
            block_live = 1'b0;
            at_slow    = '0;
            at_mid     = '0;
            at_fast    = '0;
            at_word    = '0;
            base_slow  = '0;
            base_mid   = '0;
            base_fast  = '0;
            size_slow  = '0;
            size_mid   = '0;
            size_fast  = '0;
            errors     = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_GRID_SLOW:     grid_dim_s = value[GRID_W-1:0];
                REG_GRID_MID:      grid_dim_m = value[GRID_W-1:0];
                REG_GRID_FAST:     grid_dim_f = value[GRID_W-1:0];
                REG_ELEMENT_COUNT: word_cfg = value[EC_W-1:0];
                REG_COPY_MODE:     mode = copy_mode_t'(value[1:0]);
                default:           ;
            endcase
        endfunction

        function logic [GRID_W-1:0] clamp_size(logic [GRID_W-1:0] v);
            return (v > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : v;
        endfunction

        function int word_count();
            if (word_cfg == '0)
            begin
                return 1;
            end
            if (int'(word_cfg) > int'(MAX_WORDS))
            begin
                return int'(MAX_WORDS);
            end
            return int'(word_cfg);
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void note_request(in_item_t req);
            longint unsigned words, grid_word, packed_word;
            longint unsigned s, m, f, e, ns, nm, nf;
            bit              last;
            out_item_t       pair;
            if (req.func == FUNC_LOAD)
            begin
                base_slow  = req.start_slow;
                base_mid   = req.start_mid;
                base_fast  = req.start_fast;
                size_slow  = clamp_size(req.extent_slow);
                size_mid   = clamp_size(req.extent_mid);
                size_fast  = clamp_size(req.extent_fast);
                at_slow    = '0;
                at_mid     = '0;
                at_fast    = '0;
                at_word    = '0;
                block_live = (size_slow != '0) && (size_mid != '0) && (size_fast != '0);
                return;
            end
            if (!block_live)
            begin
                return;
            end
            words = longint'(word_count());
            s  = longint'(at_slow);
            m  = longint'(at_mid);
            f  = longint'(at_fast);
            e  = longint'(at_word);
            ns = longint'(size_slow);
            nm = longint'(size_mid);
            nf = longint'(size_fast);
            grid_word = words * ((longint'(base_fast) + f) + longint'(grid_dim_f) *
                        ((longint'(base_mid) + m) + longint'(grid_dim_m) *
                        (longint'(base_slow) + s))) + e;
            case (mode)
                MODE_ROT1: packed_word = words * (s + ns * (f + nf * m)) + e;
                MODE_ROT2: packed_word = words * (m + nm * (s + ns * f)) + e;
                default:   packed_word = words * (f + nf * (m + nm * s)) + e;
            endcase
            if (mode == MODE_UNPACK)
            begin
                pair.src_index = packed_word[INDEX_W-1:0];
                pair.dst_index = grid_word[INDEX_W-1:0];
            end
            else
            begin
                pair.src_index = grid_word[INDEX_W-1:0];
                pair.dst_index = packed_word[INDEX_W-1:0];
            end
            last = (e + 1 >= words) && (f + 1 >= nf) && (m + 1 >= nm) && (s + 1 >= ns);
            pair.last_flag = last;
            expected_pairs.push_back(pair);
            if (last)
            begin
                block_live = 1'b0;
                at_slow    = '0;
                at_mid     = '0;
                at_fast    = '0;
                at_word    = '0;
            end
            else if (e + 1 < words)
            begin
                at_word = WORD_W'(e + 1);
            end
            else
            begin
                at_word = '0;
                if (f + 1 < nf)
                begin
                    at_fast = CNT_W'(f + 1);
                end
                else
                begin
                    at_fast = '0;
                    if (m + 1 < nm)
                    begin
                        at_mid = CNT_W'(m + 1);
                    end
                    else
                    begin
                        at_mid  = '0;
                        at_slow = (s + 1 < ns) ? CNT_W'(s + 1) : '0;
                    end
                end
            end
        endfunction

        function void check_pair(out_item_t got);
            out_item_t want;
            if (expected_pairs.size() == 0)
            begin
                errors++;
                $error("unexpected index pair src_index %0d dst_index %0d last_flag %0d",
                       got.src_index, got.dst_index, got.last_flag);
                return;
            end
            want = expected_pairs.pop_front();
            if (got.src_index !== want.src_index)
            begin
                errors++;
                $error("src_index expected %0d actual %0d", want.src_index, got.src_index);
            end
            if (got.dst_index !== want.dst_index)
            begin
                errors++;
                $error("dst_index expected %0d actual %0d", want.dst_index, got.dst_index);
            end
            if (got.last_flag !== want.last_flag)
            begin
                errors++;
                $error("last_flag expected %0d actual %0d", want.last_flag, got.last_flag);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                cmd_valid;
    logic                cmd_stall;
    in_item_t            cmd;
    logic                rsp_valid;
    logic                rsp_stall;
    out_item_t           rsp;

    pair_scoreboard      sb = new();
    int                  burst_left = 0;
    int                  phase_items = 0;
    int                  quiet_cycles = 0;
    int                  stall_left = 0;
    int                  stall_style = 0;

    block_pack_address_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            sb.note_request(cmd);
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            sb.check_pair(rsp);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(4, 60);
        end
        else
        begin
            stall_left--;
        end
        case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[block_pack_address_generator] ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input in_item_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd       <= req;
        do @(posedge clk); while (cmd_stall);
    endtask

    task automatic send_step();
        in_item_t req;
        req.func        = FUNC_STEP;
        req.start_slow  = START_W'($urandom_range(0, 255));
        req.start_mid   = START_W'($urandom_range(0, 255));
        req.start_fast  = START_W'($urandom_range(0, 255));
        req.extent_slow = GRID_W'($urandom_range(0, 511));
        req.extent_mid  = GRID_W'($urandom_range(0, 511));
        req.extent_fast = GRID_W'($urandom_range(0, 511));
        send_request(req);
    endtask

    task automatic send_load(input logic [START_W-1:0] c_s, c_m, c_f,
                             input logic [GRID_W-1:0] n_s, n_m, n_f);
        in_item_t req;
        req.func        = FUNC_LOAD;
        req.start_slow  = c_s;
        req.start_mid   = c_m;
        req.start_fast  = c_f;
        req.extent_slow = n_s;
        req.extent_mid  = n_m;
        req.extent_fast = n_f;
        send_request(req);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
    endtask

    task automatic load_settings(input logic [GRID_W-1:0] gs, gm, gf,
                                 input logic [EC_W-1:0] ec, input copy_mode_t mode);
        apb_write(REG_GRID_SLOW, DATA_W'(gs));
        apb_write(REG_GRID_MID, DATA_W'(gm));
        apb_write(REG_GRID_FAST, DATA_W'(gf));
        apb_write(REG_ELEMENT_COUNT, DATA_W'(ec));
        apb_write(REG_COPY_MODE, DATA_W'(mode));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_and_settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_block();
        in_item_t req;
        int       length;
        int       steps;
        req.func       = FUNC_LOAD;
        req.start_slow = START_W'($urandom_range(0, 255));
        req.start_mid  = START_W'($urandom_range(0, 255));
        req.start_fast = START_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
        begin
            req.extent_slow = GRID_W'($urandom_range(0, 511));
            req.extent_mid  = GRID_W'($urandom_range(0, 511));
            req.extent_fast = GRID_W'($urandom_range(0, 511));
        end
        else
        begin
            req.extent_slow = GRID_W'($urandom_range(1, 4));
            req.extent_mid  = GRID_W'($urandom_range(1, 4));
            req.extent_fast = GRID_W'($urandom_range(1, 4));
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       req.extent_slow = GRID_W'($urandom_range(5, 300));
                    1:       req.extent_mid  = GRID_W'($urandom_range(5, 300));
                    default: req.extent_fast = GRID_W'($urandom_range(5, 300));
                endcase
            end
        end
        length = int'(sb.clamp_size(req.extent_slow)) * int'(sb.clamp_size(req.extent_mid)) *
                 int'(sb.clamp_size(req.extent_fast)) * sb.word_count();
        send_request(req);
        steps = length;
        if (steps > 40)
        begin
            steps = $urandom_range(5, 40);
        end
        else if (steps > 0 && $urandom_range(0, 7) == 0)
        begin
            steps = $urandom_range(1, steps);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            steps += $urandom_range(1, 3);
        end
        phase_items += 1 + ((steps < length) ? steps : length);
        repeat (steps) send_step();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(GRID_W'(256), GRID_W'(256), GRID_W'(256), EC_W'(4), MODE_UNPACK);
        send_step();
        send_load(8'd0, 8'd0, 8'd0, 9'd0, 9'd5, 9'd5);
        send_step();
        send_load(8'd255, 8'd255, 8'd255, 9'd511, 9'd256, 9'd257);
        repeat (3) send_step();
        send_load(8'd0, 8'd0, 8'd0, 9'd1, 9'd1, 9'd1);
        repeat (5) send_step();
        send_load(8'd3, 8'd4, 8'd5, 9'd2, 9'd2, 9'd2);
        repeat (3) send_step();
        send_load(8'd0, 8'd0, 8'd0, 9'd1, 9'd1, 9'd2);
        repeat (2) send_step();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_and_settle();
            case (p)
                0: load_settings(GRID_W'(1), GRID_W'(1), GRID_W'(1), EC_W'(1), MODE_PACK);
                1: load_settings(GRID_W'(256), GRID_W'(256), GRID_W'(256), EC_W'(4),
                                 MODE_ROT1);
                2: load_settings(GRID_W'($urandom_range(1, 256)), GRID_W'($urandom_range(1, 256)),
                                 GRID_W'($urandom_range(1, 256)), EC_W'($urandom_range(1, 4)),
                                 MODE_ROT2);
                3: load_settings(GRID_W'($urandom_range(1, 256)), GRID_W'($urandom_range(1, 256)),
                                 GRID_W'($urandom_range(1, 256)), EC_W'($urandom_range(1, 4)),
                                 MODE_UNPACK);
                4: load_settings(GRID_W'($urandom_range(1, 256)), GRID_W'($urandom_range(1, 256)),
                                 GRID_W'($urandom_range(1, 256)), EC_W'($urandom_range(1, 4)),
                                 MODE_PACK);
                5: load_settings(GRID_W'(0), GRID_W'(511), GRID_W'($urandom_range(0, 511)),
                                 EC_W'(0), copy_mode_t'($urandom_range(0, 3)));
                6: load_settings(GRID_W'($urandom_range(1, 256)), GRID_W'($urandom_range(1, 256)),
                                 GRID_W'($urandom_range(1, 256)), EC_W'(7),
                                 copy_mode_t'($urandom_range(0, 3)));
                default: load_settings(GRID_W'($urandom_range(1, 256)),
                                       GRID_W'($urandom_range(1, 256)),
                                       GRID_W'($urandom_range(1, 256)),
                                       EC_W'($urandom_range(1, 4)),
                                       copy_mode_t'($urandom_range(0, 3)));
            endcase
            repeat ($urandom_range(0, 6)) send_step();
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) run_block();
        end

        drain_and_settle();
        if (sb.errors == 0)
        begin
            $display("[block_pack_address_generator] OK");
        end
        else
        begin
            $display("[block_pack_address_generator] ERROR");
        end
        $finish;
    end

endmodule

// ----- block_pack_address_generator.f -----
rtl/bpag_pkg.sv
rtl/bpag_regs.sv
rtl/bpag_ctrl.sv
rtl/bpag_datapath.sv
rtl/block_pack_address_generator.sv
rtl/bpag_checker.sv
bench/testbench.sv
